FILE: sv/dsgl_pkg.sv
// shared types, widths and codes of the direct-sum gravity block
package dsgl_pkg;

  // default store depth
  localparam int MAX_BODIES_DEF = 1024;

  // word and datapath widths
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 10;
  localparam int COUNT_W  = 11;
  localparam int S_W      = 68;   // sum of squares, even width for the root digits
  localparam int ROOT_W   = 34;
  localparam int SQ_STEPS = 34;
  localparam int NUM_W    = 112;  // G*m*|d| with 16 extra fraction bits
  localparam int DEN_W    = 101;  // s*root
  localparam int REM_W    = 102;
  localparam int QUO_W    = 32;
  localparam int TERM_W   = 33;

  // operation codes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_STEP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // register indexes
  localparam logic [1:0] REG_GRAVITY  = 2'd0;
  localparam logic [1:0] REG_SOFTEN   = 2'd1;
  localparam logic [1:0] REG_TIMESTEP = 2'd2;
  localparam logic [1:0] REG_COUNT    = 2'd3;

  // register reset values
  localparam logic [31:0] GRAVITY_RST  = 32'd65536;
  localparam logic [31:0] SOFTEN_RST   = 32'd655;
  localparam logic [31:0] TIMESTEP_RST = 32'd655;

  typedef struct packed {
    logic [1:0]         operation;
    logic [9:0]         body_index;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_pos_z;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic signed [31:0] load_vel_z;
    logic signed [31:0] load_acc_x;
    logic signed [31:0] load_acc_y;
    logic signed [31:0] load_acc_z;
    logic [31:0]        load_mass;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [9:0]         out_index;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic signed [31:0] out_acc_x;
    logic signed [31:0] out_acc_y;
    logic signed [31:0] out_acc_z;
  } out_item_t;

  // one store entry, axis 0 is x
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] acc;
    logic [31:0]      mass;
  } body_t;

  // divider lane control
  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

endpackage

FILE: sv/dsgl_divlane.sv
// restoring divider lane: min(floor(num/den), 2^32), one quotient bit per cycle while step is high
module dsgl_divlane (
  input  logic                         clk,
  input  dsgl_pkg::div_ctl_t           ctl,
  input  logic [dsgl_pkg::NUM_W-1:0]   num,
  input  logic [dsgl_pkg::DEN_W-1:0]   den,
  output logic [dsgl_pkg::TERM_W-1:0]  term
);

  logic [dsgl_pkg::REM_W-1:0] rem_r;
  logic [dsgl_pkg::QUO_W-1:0] low_r;
  logic [dsgl_pkg::QUO_W-1:0] q_r;
  logic                       clamp_r;
  logic [dsgl_pkg::REM_W-1:0] rem_sh;
  logic [dsgl_pkg::REM_W-1:0] num_top;
  logic                       ge;

  // shift in the next dividend bit and trial subtract
  assign rem_sh  = {rem_r[dsgl_pkg::DEN_W-1:0], low_r[dsgl_pkg::QUO_W-1]};
  assign ge      = rem_sh >= dsgl_pkg::REM_W'(den);
  assign num_top = dsgl_pkg::REM_W'(num[dsgl_pkg::NUM_W-1:dsgl_pkg::QUO_W]);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r   <= num_top;
      low_r   <= num[dsgl_pkg::QUO_W-1:0];
      q_r     <= '0;
      clamp_r <= num_top >= dsgl_pkg::REM_W'(den);
    end else if (ctl.step) begin
      rem_r <= ge ? rem_sh - dsgl_pkg::REM_W'(den) : rem_sh;
      low_r <= {low_r[dsgl_pkg::QUO_W-2:0], 1'b0};
      q_r   <= {q_r[dsgl_pkg::QUO_W-2:0], ge};
    end
  end

  // quotient of 2^32 or more clamps
  assign term = clamp_r ? {1'b1, {dsgl_pkg::QUO_W{1'b0}}} : dsgl_pkg::TERM_W'(q_r);

endmodule

FILE: sv/direct_sum_gravity_leapfrog.sv
// direct-sum gravity with one velocity-Verlet step per step command
//
//  port group  | dir | beat
//  in_*        | in  | load, step or read command with body data
//  out_*       | out | body read data or step finished
//  cfg_*       | in  | register write, no wait
//
// load writes the store directly; a read passes the store read register and
// then the output register. a step works one body pair at a time, each pair
// through a square root and then the dividers. reset is synchronous, clears
// control and sets the config registers to their defaults; the body store
// holds garbage until loaded. in_ready is high only while no command is in
// progress; a held output beat stalls the block before it writes the next result.
module direct_sum_gravity_leapfrog #(
  parameter int MAX_BODIES = dsgl_pkg::MAX_BODIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dsgl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dsgl_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_BODIES);
  localparam int CNT_W  = $clog2(MAX_BODIES + 1);
  localparam int SUM_W  = dsgl_pkg::TERM_W + 1 + ADDR_W;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RDOUT  = 5'd1;
  localparam logic [4:0] S_DR_RD  = 5'd2;
  localparam logic [4:0] S_DR_A   = 5'd3;
  localparam logic [4:0] S_DR_B   = 5'd4;
  localparam logic [4:0] S_DR_C   = 5'd5;
  localparam logic [4:0] S_FI_RD  = 5'd6;
  localparam logic [4:0] S_FI_LD  = 5'd7;
  localparam logic [4:0] S_FJ_RD  = 5'd8;
  localparam logic [4:0] S_FJ_D0  = 5'd9;
  localparam logic [4:0] S_FJ_D1  = 5'd10;
  localparam logic [4:0] S_FJ_D2  = 5'd11;
  localparam logic [4:0] S_FJ_SQ  = 5'd12;
  localparam logic [4:0] S_FJ_N0  = 5'd13;
  localparam logic [4:0] S_FJ_N1  = 5'd14;
  localparam logic [4:0] S_FJ_N2  = 5'd15;
  localparam logic [4:0] S_FJ_DIV = 5'd16;
  localparam logic [4:0] S_FJ_ACC = 5'd17;
  localparam logic [4:0] S_FI_WR  = 5'd18;
  localparam logic [4:0] S_KI_RD  = 5'd19;
  localparam logic [4:0] S_KI_A   = 5'd20;
  localparam logic [4:0] S_KI_B   = 5'd21;
  localparam logic [4:0] S_DONE   = 5'd22;

  // saturate to the signed word range
  function automatic logic signed [31:0] sat_word(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -hi - 64'sd1;
    if (x > hi) return hi[31:0];
    else if (x < lo) return lo[31:0];
    else return x[31:0];
  endfunction

  // floor(x*dt / 2^16)
  function automatic logic signed [47:0] scale_dt(input logic signed [31:0] x,
                                                  input logic [31:0] dt);
    logic signed [64:0] p;
    p = $signed(x) * $signed({1'b0, dt});
    return p[63:16];
  endfunction

  // sat(floor(a*dt / 2^17))
  function automatic logic signed [31:0] half_kick(input logic signed [31:0] a,
                                                   input logic [31:0] dt);
    logic signed [64:0] p;
    p = $signed(a) * $signed({1'b0, dt});
    return sat_word(64'(p >>> 17));
  endfunction

  // configuration registers
  logic [31:0]                  grav_r, eps_r, dt_r;
  logic [dsgl_pkg::COUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r  <= dsgl_pkg::GRAVITY_RST;
      eps_r   <= dsgl_pkg::SOFTEN_RST;
      dt_r    <= dsgl_pkg::TIMESTEP_RST;
      count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsgl_pkg::REG_GRAVITY:  grav_r  <= cfg_wdata;
        dsgl_pkg::REG_SOFTEN:   eps_r   <= cfg_wdata;
        dsgl_pkg::REG_TIMESTEP: dt_r    <= cfg_wdata;
        dsgl_pkg::REG_COUNT:    count_r <= cfg_wdata[dsgl_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [4:0]                  state_r, state_nxt;
  logic [CNT_W-1:0]            i_r, i_nxt, j_r, j_nxt, n_r, n_nxt;
  logic [dsgl_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                        rng_r, rng_nxt;
  logic [5:0]                  cnt_r, cnt_nxt;
  logic                        out_valid_r;
  dsgl_pkg::out_item_t         out_data_r, out_data_nxt;

  // body store
  dsgl_pkg::body_t             body_mem [MAX_BODIES];
  dsgl_pkg::body_t             body_rd_r;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr, mem_raddr;
  dsgl_pkg::body_t             mem_wdata;

  // datapath registers
  dsgl_pkg::body_t             ent_r;
  logic signed [31:0]          h_r [3];
  logic signed [47:0]          vdt_r [3];
  logic signed [47:0]          hdt_r [3];
  logic [32:0]                 ad_r [3];
  logic                        neg_r [3];
  logic [31:0]                 mj_r;
  logic [65:0]                 sq_r [3];
  logic [63:0]                 eps2_r;
  logic [63:0]                 gm_r;
  logic [64:0]                 nlo_r [3];
  logic [64:0]                 nhi_r [3];
  logic [dsgl_pkg::NUM_W-1:0]  num_r [3];
  logic [dsgl_pkg::S_W-1:0]    s_r, sq_sh_r;
  logic [36:0]                 sq_rem_r;
  logic [dsgl_pkg::ROOT_W-1:0] root_r;
  logic [67:0]                 dlo_r, dhi_r;
  logic [dsgl_pkg::DEN_W-1:0]  den_r;
  logic signed [SUM_W-1:0]     sum_r [3];
  logic [dsgl_pkg::TERM_W-1:0] term [3];

  // combinational datapath values
  logic signed [31:0]          hk_c [3];
  logic signed [47:0]          vdt_c [3];
  logic signed [47:0]          hdt_c [3];
  logic signed [31:0]          pnew_c [3];
  logic signed [31:0]          vnew_c [3];
  logic signed [32:0]          d_c [3];
  logic [dsgl_pkg::S_W-1:0]    s_c;
  logic [36:0]                 rem_sh_c, trial_c;
  logic                        sq_ge_c;
  logic                        in_rng_c;
  logic [CNT_W-1:0]            n_cfg_c;
  logic                        out_free;
  dsgl_pkg::div_ctl_t          div_ctl;

  assign in_rng_c = {22'd0, in_data.body_index} < 32'(MAX_BODIES);
  assign n_cfg_c  = (32'(count_r) > 32'(MAX_BODIES)) ? CNT_W'(MAX_BODIES) : CNT_W'(count_r);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // per-axis arithmetic
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hk_c[k]   = half_kick($signed(body_rd_r.acc[k]), dt_r);
      vdt_c[k]  = scale_dt($signed(body_rd_r.vel[k]), dt_r);
      hdt_c[k]  = scale_dt(h_r[k], dt_r);
      pnew_c[k] = sat_word(64'($signed(ent_r.pos[k])) + 64'(vdt_r[k]) + 64'(hdt_r[k]));
      vnew_c[k] = sat_word(64'($signed(ent_r.vel[k])) + 64'(h_r[k]));
      d_c[k]    = $signed({body_rd_r.pos[k][31], body_rd_r.pos[k]})
                - $signed({ent_r.pos[k][31], ent_r.pos[k]});
    end
    s_c = dsgl_pkg::S_W'(sq_r[0]) + dsgl_pkg::S_W'(sq_r[1])
        + dsgl_pkg::S_W'(sq_r[2]) + dsgl_pkg::S_W'(eps2_r);
  end

  // square root digit step
  assign rem_sh_c = {sq_rem_r[34:0], sq_sh_r[dsgl_pkg::S_W-1 -: 2]};
  assign trial_c  = 37'({root_r, 2'b01});
  assign sq_ge_c  = rem_sh_c >= trial_c;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    rng_nxt   = rng_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.operation)
            dsgl_pkg::OP_STEP: begin
              n_nxt     = n_cfg_c;
              i_nxt     = '0;
              state_nxt = (n_cfg_c == '0) ? S_DONE : S_DR_RD;
            end
            dsgl_pkg::OP_READ: begin
              idx_nxt   = in_data.body_index;
              rng_nxt   = in_rng_c;
              state_nxt = S_RDOUT;
            end
            default: ;
          endcase
        end
      end
      S_RDOUT:  if (out_free) state_nxt = S_IDLE;
      S_DR_RD:  state_nxt = S_DR_A;
      S_DR_A:   state_nxt = S_DR_B;
      S_DR_B:   state_nxt = S_DR_C;
      S_DR_C: begin
        if (CNT_W'(i_r + 1'b1) == n_r) begin
          i_nxt     = '0;
          state_nxt = S_FI_RD;
        end else begin
          i_nxt     = CNT_W'(i_r + 1'b1);
          state_nxt = S_DR_RD;
        end
      end
      S_FI_RD:  state_nxt = S_FI_LD;
      S_FI_LD: begin
        j_nxt     = '0;
        state_nxt = S_FJ_RD;
      end
      S_FJ_RD:  state_nxt = S_FJ_D0;
      S_FJ_D0:  state_nxt = S_FJ_D1;
      S_FJ_D1:  state_nxt = S_FJ_D2;
      S_FJ_D2: begin
        cnt_nxt   = 6'(dsgl_pkg::SQ_STEPS - 1);
        state_nxt = S_FJ_SQ;
      end
      S_FJ_SQ: begin
        if (cnt_r == '0) state_nxt = S_FJ_N0;
        else cnt_nxt = cnt_r - 6'd1;
      end
      S_FJ_N0:  state_nxt = S_FJ_N1;
      S_FJ_N1:  state_nxt = S_FJ_N2;
      S_FJ_N2: begin
        cnt_nxt   = 6'(dsgl_pkg::QUO_W - 1);
        state_nxt = S_FJ_DIV;
      end
      S_FJ_DIV: begin
        if (cnt_r == '0) state_nxt = S_FJ_ACC;
        else cnt_nxt = cnt_r - 6'd1;
      end
      S_FJ_ACC: begin
        if (CNT_W'(j_r + 1'b1) == n_r) begin
          state_nxt = S_FI_WR;
        end else begin
          j_nxt     = CNT_W'(j_r + 1'b1);
          state_nxt = S_FJ_RD;
        end
      end
      S_FI_WR: begin
        if (CNT_W'(i_r + 1'b1) == n_r) begin
          i_nxt     = '0;
          state_nxt = S_KI_RD;
        end else begin
          i_nxt     = CNT_W'(i_r + 1'b1);
          state_nxt = S_FI_RD;
        end
      end
      S_KI_RD:  state_nxt = S_KI_A;
      S_KI_A:   state_nxt = S_KI_B;
      S_KI_B: begin
        if (CNT_W'(i_r + 1'b1) == n_r) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt     = CNT_W'(i_r + 1'b1);
          state_nxt = S_KI_RD;
        end
      end
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      n_r     <= '0;
      idx_r   <= '0;
      rng_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      n_r     <= n_nxt;
      idx_r   <= idx_nxt;
      rng_r   <= rng_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // store address and write data
  always_comb begin
    priority if (state_r == S_FJ_RD) mem_raddr = j_r[ADDR_W-1:0];
    else if (state_r == S_IDLE)      mem_raddr = ADDR_W'(in_data.body_index);
    else if (state_r == S_RDOUT)     mem_raddr = ADDR_W'(idx_r);
    else                             mem_raddr = i_r[ADDR_W-1:0];

    mem_we    = 1'b0;
    mem_waddr = i_r[ADDR_W-1:0];
    mem_wdata = ent_r;
    unique case (state_r)
      S_IDLE: begin
        mem_we      = in_valid && (in_data.operation == dsgl_pkg::OP_LOAD) && in_rng_c;
        mem_waddr   = ADDR_W'(in_data.body_index);
        mem_wdata.pos[0] = in_data.load_pos_x;
        mem_wdata.pos[1] = in_data.load_pos_y;
        mem_wdata.pos[2] = in_data.load_pos_z;
        mem_wdata.vel[0] = in_data.load_vel_x;
        mem_wdata.vel[1] = in_data.load_vel_y;
        mem_wdata.vel[2] = in_data.load_vel_z;
        mem_wdata.acc[0] = in_data.load_acc_x;
        mem_wdata.acc[1] = in_data.load_acc_y;
        mem_wdata.acc[2] = in_data.load_acc_z;
        mem_wdata.mass   = in_data.load_mass;
      end
      S_DR_C: begin
        mem_we = 1'b1;
        for (int k = 0; k < 3; k++) begin
          mem_wdata.pos[k] = pnew_c[k];
          mem_wdata.vel[k] = vnew_c[k];
        end
      end
      S_FI_WR: begin
        mem_we = 1'b1;
        for (int k = 0; k < 3; k++) mem_wdata.acc[k] = sat_word(64'(sum_r[k]));
      end
      S_KI_B: begin
        mem_we = 1'b1;
        for (int k = 0; k < 3; k++) mem_wdata.vel[k] = vnew_c[k];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) body_mem[mem_waddr] <= mem_wdata;
    body_rd_r <= body_mem[mem_raddr];
  end

  // datapath registers per state
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_DR_A, S_KI_A: begin
        ent_r <= body_rd_r;
        for (int k = 0; k < 3; k++) begin
          h_r[k]   <= hk_c[k];
          vdt_r[k] <= vdt_c[k];
        end
      end
      S_DR_B: for (int k = 0; k < 3; k++) hdt_r[k] <= hdt_c[k];
      S_FI_LD: begin
        ent_r <= body_rd_r;
        for (int k = 0; k < 3; k++) sum_r[k] <= '0;
      end
      S_FJ_D0: begin
        mj_r <= body_rd_r.mass;
        for (int k = 0; k < 3; k++) begin
          neg_r[k] <= d_c[k][32];
          ad_r[k]  <= d_c[k][32] ? 33'(-d_c[k]) : 33'(d_c[k]);
        end
      end
      S_FJ_D1: begin
        for (int k = 0; k < 3; k++) sq_r[k] <= ad_r[k] * ad_r[k];
        eps2_r <= eps_r * eps_r;
        gm_r   <= grav_r * mj_r;
      end
      S_FJ_D2: begin
        s_r      <= s_c;
        sq_sh_r  <= s_c;
        sq_rem_r <= '0;
        root_r   <= '0;
        for (int k = 0; k < 3; k++) begin
          nlo_r[k] <= gm_r[31:0] * ad_r[k];
          nhi_r[k] <= gm_r[63:32] * ad_r[k];
        end
      end
      S_FJ_SQ: begin
        sq_sh_r  <= {sq_sh_r[dsgl_pkg::S_W-3:0], 2'b00};
        sq_rem_r <= sq_ge_c ? rem_sh_c - trial_c : rem_sh_c;
        root_r   <= {root_r[dsgl_pkg::ROOT_W-2:0], sq_ge_c};
      end
      S_FJ_N0: begin
        dlo_r <= s_r[33:0] * root_r;
        dhi_r <= s_r[67:34] * root_r;
        for (int k = 0; k < 3; k++) begin
          num_r[k] <= (dsgl_pkg::NUM_W'({nhi_r[k], 32'd0}) + dsgl_pkg::NUM_W'(nlo_r[k]))
                      << 16;
        end
      end
      S_FJ_N1: den_r <= dsgl_pkg::DEN_W'(dsgl_pkg::DEN_W'(dlo_r)
                      + (dsgl_pkg::DEN_W'(dhi_r) << 34));
      S_FJ_ACC: begin
        // self pair and zero distance with no softening add nothing
        if (j_r != i_r && s_r != '0) begin
          for (int k = 0; k < 3; k++) begin
            sum_r[k] <= neg_r[k] ? sum_r[k] - $signed(SUM_W'(term[k]))
                                 : sum_r[k] + $signed(SUM_W'(term[k]));
          end
        end
      end
      default: ;
    endcase
  end

  // divider lanes, one per axis
  assign div_ctl.load = (state_r == S_FJ_N2);
  assign div_ctl.step = (state_r == S_FJ_DIV);

  for (genvar k = 0; k < 3; k++) begin : g_div
    dsgl_divlane u_div (
      .clk  (clk),
      .ctl  (div_ctl),
      .num  (num_r[k]),
      .den  (den_r),
      .term (term[k])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RDOUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // next output beat: step done or body read data
  always_comb begin
    out_data_nxt = '0;
    if (state_r == S_DONE) begin
      out_data_nxt.kind = dsgl_pkg::KIND_DONE;
    end else begin
      out_data_nxt.kind      = dsgl_pkg::KIND_READ;
      out_data_nxt.out_index = idx_r;
      if (rng_r) begin
        out_data_nxt.out_pos_x = body_rd_r.pos[0];
        out_data_nxt.out_pos_y = body_rd_r.pos[1];
        out_data_nxt.out_pos_z = body_rd_r.pos[2];
        out_data_nxt.out_vel_x = body_rd_r.vel[0];
        out_data_nxt.out_vel_y = body_rd_r.vel[1];
        out_data_nxt.out_vel_z = body_rd_r.vel[2];
        out_data_nxt.out_acc_x = body_rd_r.acc[0];
        out_data_nxt.out_acc_y = body_rd_r.acc[1];
        out_data_nxt.out_acc_z = body_rd_r.acc[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_RDOUT || state_r == S_DONE) && out_free) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_read_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation == dsgl_pkg::OP_READ |=> state_r == S_RDOUT)
    else $error("read beat did not move to output state");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RDOUT || $past(state_r) == S_DONE)
    else $error("output beat raised outside a result state");

  a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FJ_RD |-> j_r < n_r && i_r < n_r)
    else $error("pair index past body count");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.kind == dsgl_pkg::KIND_DONE |-> out_data_r.out_index == '0)
    else $error("step result carries an index");
`endif

endmodule

FILE: bench/tb_direct_sum_gravity_leapfrog.sv
// testbench for the direct-sum gravity block: directed table, then random phases
module tb_direct_sum_gravity_leapfrog;

  localparam int NBODY = 1024;

  // operation code with no meaning, must be dropped
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  dsgl_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  dsgl_pkg::out_item_t out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = dsgl_pkg::REG_GRAVITY;
  logic [31:0] cfg_wdata = '0;

  direct_sum_gravity_leapfrog u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // shadow copy of the body store and registers
  int          pos_m [NBODY][3];
  int          vel_m [NBODY][3];
  int          acc_m [NBODY][3];
  int unsigned mass_m [NBODY];
  int unsigned grav_r = dsgl_pkg::GRAVITY_RST;
  int unsigned soft_r = dsgl_pkg::SOFTEN_RST;
  int unsigned dt_r   = dsgl_pkg::TIMESTEP_RST;
  int unsigned count_r = 0;

  dsgl_pkg::out_item_t pending_q [$];
  int        errors = 0;
  int        stall_cnt = 0;
  int        hold_cnt = 0;
  bit        send_quiet = 0;
  bit        recv_quiet = 0;
  bit        loaded [NBODY];
  int        loaded_q [$];

  function automatic int sat32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  function automatic int half_kick(int a);
    longint p;
    p = longint'(a) * longint'(dt_r);
    return sat32(p >>> 17);
  endfunction

  // pairwise softened attraction on body i from all others
  function automatic void gravitate(int i, int n);
    longint      sum [3];
    longint      d [3];
    logic [127:0] ad [3];
    logic [127:0] s, root, c, den, gm, num, q;
    longint      t;
    sum = '{0, 0, 0};
    for (int j = 0; j < n; j++) begin
      if (j == i) continue;
      s = 128'(soft_r) * 128'(soft_r);
      for (int k = 0; k < 3; k++) begin
        d[k] = longint'(pos_m[j][k]) - longint'(pos_m[i][k]);
        ad[k] = 128'(d[k] < 0 ? -d[k] : d[k]);
        s = s + ad[k] * ad[k];
      end
      if (s == 0) continue;
      root = '0;
      for (int b = 33; b >= 0; b--) begin
        c = root | (128'd1 << b);
        if (c * c <= s) root = c;
      end
      den = s * root;
      gm = 128'(grav_r) * 128'(mass_m[j]);
      for (int k = 0; k < 3; k++) begin
        if (ad[k] == 0) continue;
        num = (gm * ad[k]) << 16;
        q = num / den;
        if (q > (128'd1 << 32)) q = 128'd1 << 32;
        t = longint'(q[33:0]);
        sum[k] += d[k] < 0 ? -t : t;
      end
    end
    for (int k = 0; k < 3; k++) acc_m[i][k] = sat32(sum[k]);
  endfunction

  // one velocity-Verlet step over the bodies in use
  function automatic void leapfrog_step();
    int     n;
    int     h;
    longint dtl;
    n = count_r > NBODY ? NBODY : count_r;
    dtl = longint'(dt_r);
    for (int i = 0; i < n; i++)
      for (int k = 0; k < 3; k++) begin
        h = half_kick(acc_m[i][k]);
        pos_m[i][k] = sat32(longint'(pos_m[i][k]) + ((longint'(vel_m[i][k]) * dtl) >>> 16)
                            + ((longint'(h) * dtl) >>> 16));
        vel_m[i][k] = sat32(longint'(vel_m[i][k]) + h);
      end
    for (int i = 0; i < n; i++) gravitate(i, n);
    for (int i = 0; i < n; i++)
      for (int k = 0; k < 3; k++)
        vel_m[i][k] = sat32(longint'(vel_m[i][k]) + half_kick(acc_m[i][k]));
  endfunction

  // apply one command, return the body or done beat it produces
  function automatic bit body_result(dsgl_pkg::in_item_t it, output dsgl_pkg::out_item_t r);
    int b;
    r = '0;
    b = int'(it.body_index);
    case (it.operation)
      dsgl_pkg::OP_LOAD: begin
        pos_m[b] = '{it.load_pos_x, it.load_pos_y, it.load_pos_z};
        vel_m[b] = '{it.load_vel_x, it.load_vel_y, it.load_vel_z};
        acc_m[b] = '{it.load_acc_x, it.load_acc_y, it.load_acc_z};
        mass_m[b] = it.load_mass;
        return 0;
      end
      dsgl_pkg::OP_STEP: begin
        leapfrog_step();
        r.kind = dsgl_pkg::KIND_DONE;
        return 1;
      end
      dsgl_pkg::OP_READ: begin
        r.kind = dsgl_pkg::KIND_READ;
        r.out_index = it.body_index;
        r.out_pos_x = pos_m[b][0]; r.out_pos_y = pos_m[b][1]; r.out_pos_z = pos_m[b][2];
        r.out_vel_x = vel_m[b][0]; r.out_vel_y = vel_m[b][1]; r.out_vel_z = vel_m[b][2];
        r.out_acc_x = acc_m[b][0]; r.out_acc_y = acc_m[b][1]; r.out_acc_z = acc_m[b][2];
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // offer one beat; typed expectation overrides the predicted one
  task automatic send_cmd(dsgl_pkg::in_item_t it, bit typed, dsgl_pkg::out_item_t want);
    dsgl_pkg::out_item_t r;
    int        gap;
    gap = send_quiet ? 0 : $urandom_range(0, 17);
    repeat (gap) @(negedge clk);
    in_data = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (body_result(it, r)) pending_q.push_back(typed ? want : r);
    if (it.operation == dsgl_pkg::OP_LOAD && !loaded[it.body_index]) begin
      loaded[it.body_index] = 1;
      loaded_q.push_back(int'(it.body_index));
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      dsgl_pkg::REG_GRAVITY:  grav_r = val;
      dsgl_pkg::REG_SOFTEN:   soft_r = val;
      dsgl_pkg::REG_TIMESTEP: dt_r = val;
      default:                count_r = 32'(val[10:0]);
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly values that keep bodies interacting, sometimes any word
  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  function automatic dsgl_pkg::in_item_t mk_cmd(logic [1:0] op, int b, logic [31:0] px,
                                                logic [31:0] py, logic [31:0] pz,
                                                logic [31:0] v, logic [31:0] a,
                                                logic [31:0] m);
    dsgl_pkg::in_item_t it;
    it = '0;
    it.operation = op;
    it.body_index = 10'(b);
    it.load_pos_x = px; it.load_pos_y = py; it.load_pos_z = pz;
    it.load_vel_x = v;  it.load_vel_y = -v; it.load_vel_z = ~v;
    it.load_acc_x = a;  it.load_acc_y = ~a; it.load_acc_z = a ^ 32'h5555aaaa;
    it.load_mass = m;
    return it;
  endfunction

  function automatic dsgl_pkg::in_item_t rnd_load(int b);
    dsgl_pkg::in_item_t it;
    it.operation = dsgl_pkg::OP_LOAD;
    it.body_index = 10'(b);
    it.load_pos_x = rnd_word(); it.load_pos_y = rnd_word(); it.load_pos_z = rnd_word();
    it.load_vel_x = rnd_word(); it.load_vel_y = rnd_word(); it.load_vel_z = rnd_word();
    it.load_acc_x = rnd_word(); it.load_acc_y = rnd_word(); it.load_acc_z = rnd_word();
    it.load_mass = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 20);
    return it;
  endfunction

  function automatic logic [31:0] rnd_reg();
    case ($urandom_range(0, 4))
      0:       return 32'h0;
      1:       return 32'hffffffff;
      2:       return $urandom;
      default: return $urandom_range(1, 1 << 17);
    endcase
  endfunction

  // directed table
  typedef struct {
    bit                  is_cfg;
    logic [1:0]          reg_idx;
    logic [31:0]         reg_val;
    dsgl_pkg::in_item_t  cmd;
    bit                  typed;
    dsgl_pkg::out_item_t want;
  } row_t;

  function automatic row_t cfg_row(logic [1:0] idx, logic [31:0] val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic row_t cmd_row(dsgl_pkg::in_item_t it);
    row_t r;
    r = '{default: '0};
    r.cmd = it;
    return r;
  endfunction

  // read of an untouched body returns exactly what was loaded
  function automatic row_t read_back(dsgl_pkg::in_item_t ld);
    row_t r;
    r = cmd_row(ld);
    r.cmd.operation = dsgl_pkg::OP_READ;
    r.typed = 1;
    r.want = '{dsgl_pkg::KIND_READ, ld.body_index, ld.load_pos_x, ld.load_pos_y,
               ld.load_pos_z, ld.load_vel_x, ld.load_vel_y, ld.load_vel_z,
               ld.load_acc_x, ld.load_acc_y, ld.load_acc_z};
    return r;
  endfunction

  function automatic row_t done_row();
    row_t r;
    r = cmd_row(mk_cmd(dsgl_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0));
    r.typed = 1;
    r.want = '0;
    r.want.kind = dsgl_pkg::KIND_DONE;
    return r;
  endfunction

  // beat check at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %h", out_data);
      end else begin
        if (out_data !== pending_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h actual %h", pending_q[0], out_data);
        end
        void'(pending_q.pop_front());
      end
      stall_cnt = recv_quiet ? 0 : $urandom_range(0, 17);
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_ready = 1'b0;
      hold_cnt--;
    end else if (stall_cnt > 0) begin
      out_ready = 1'b0;
      stall_cnt--;
    end else begin
      out_ready = 1'b1;
    end
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    row_t                rows [$];
    dsgl_pkg::in_item_t  ld0, ld1023, it;
    dsgl_pkg::out_item_t none;
    int        items;
    int        phase;
    int        nb;
    int        pick;

    none = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    ld0 = mk_cmd(dsgl_pkg::OP_LOAD, 0, 32'h7fffffff, 32'h80000000, 32'h0, 32'h80000000,
                 32'h7fffffff, 32'hffffffff);
    ld1023 = mk_cmd(dsgl_pkg::OP_LOAD, 1023, 32'h80000000, 32'h7fffffff, 32'hffffffff,
                    32'h7fffffff, 32'h80000000, 32'h0);
    rows.push_back(cmd_row(ld0));
    rows.push_back(cmd_row(ld1023));
    rows.push_back(read_back(ld0));
    rows.push_back(read_back(ld1023));
    // unknown operation is dropped
    rows.push_back(cmd_row(mk_cmd(OP_UNUSED, 1023, '1, '1, '1, '1, '1, '1)));
    // step with no bodies still answers
    rows.push_back(done_row());
    rows.push_back(read_back(ld0));
    // single body: saturating drift, acceleration cleared
    rows.push_back(cfg_row(dsgl_pkg::REG_COUNT, 1));
    rows.push_back(done_row());
    rows.push_back(cmd_row(mk_cmd(dsgl_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0)));
    // coincident bodies without softening
    rows.push_back(cfg_row(dsgl_pkg::REG_SOFTEN, 0));
    rows.push_back(cfg_row(dsgl_pkg::REG_COUNT, 2));
    rows.push_back(cmd_row(mk_cmd(dsgl_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0, 32'h10000)));
    rows.push_back(cmd_row(mk_cmd(dsgl_pkg::OP_LOAD, 1, 0, 0, 0, 0, 0, 32'h10000)));
    rows.push_back(done_row());
    rows.push_back(cmd_row(mk_cmd(dsgl_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0)));
    // separated on two axes, one axis zero
    rows.push_back(cmd_row(mk_cmd(dsgl_pkg::OP_LOAD, 1, 32'h10000, 32'hfffe0000, 0, 0, 0,
                                  32'h30000)));
    rows.push_back(done_row());
    rows.push_back(cmd_row(mk_cmd(dsgl_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(cmd_row(mk_cmd(dsgl_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0)));
    // huge gravity and time step drive saturation
    rows.push_back(cfg_row(dsgl_pkg::REG_GRAVITY, 32'hffffffff));
    rows.push_back(cfg_row(dsgl_pkg::REG_TIMESTEP, 32'hffffffff));
    rows.push_back(done_row());
    rows.push_back(cmd_row(mk_cmd(dsgl_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0)));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_idle();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_cmd(rows[i].cmd, rows[i].typed, rows[i].want);
      end
    end

    // random phases
    items = 0;
    phase = 0;
    while (items < 100) begin
      wait_idle();
      send_quiet = $urandom_range(0, 3) == 0;
      recv_quiet = $urandom_range(0, 3) == 0;
      write_reg(dsgl_pkg::REG_GRAVITY, rnd_reg());
      write_reg(dsgl_pkg::REG_SOFTEN, rnd_reg());
      write_reg(dsgl_pkg::REG_TIMESTEP, rnd_reg());
      // out-of-range and full-store counts are written but never stepped
      if (phase == 2) write_reg(dsgl_pkg::REG_COUNT, 32'd2047);
      else if (phase == 4) write_reg(dsgl_pkg::REG_COUNT, 32'd1024);
      else write_reg(dsgl_pkg::REG_COUNT, $urandom_range(0, 5));
      nb = count_r;
      if (phase != 2 && phase != 4)
        for (int b = 0; b < nb; b++)
          if (!loaded[b]) begin
            send_cmd(rnd_load(b), 0, none);
            items++;
          end
      if (phase == 3) begin
        // receiver holds off while reads pile up
        @(posedge clk);
        hold_cnt = 400;
        @(negedge clk);
        repeat (8) begin
          send_cmd(mk_cmd(dsgl_pkg::OP_READ, loaded_q[$urandom_range(0, loaded_q.size() - 1)],
                          0, 0, 0, 0, 0, 0), 0, none);
          items++;
        end
      end
      repeat ($urandom_range(4, 10)) begin
        pick = $urandom_range(0, 19);
        if (pick < 6) begin
          send_cmd(rnd_load($urandom_range(0, 2) == 0 ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, 5)), 0, none);
          items++;
        end else if (pick < 13) begin
          send_cmd(mk_cmd(dsgl_pkg::OP_READ, loaded_q[$urandom_range(0, loaded_q.size() - 1)],
                          0, 0, 0, 0, 0, 0), 0, none);
          items++;
        end else if (pick < 18) begin
          if (phase != 2 && phase != 4) begin
            for (int b = 0; b < nb; b++)
              if (!loaded[b]) send_cmd(rnd_load(b), 0, none);
            send_cmd(mk_cmd(dsgl_pkg::OP_STEP, $urandom_range(0, 1023), 0, 0, 0, 0, 0, 0),
                     0, none);
            items++;
          end
        end else begin
          it = rnd_load($urandom_range(0, 1023));
          it.operation = OP_UNUSED;
          send_cmd(it, 0, none);
        end
      end
      phase++;
    end

    wait_idle();
    repeat (200) @(negedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/dsgl_pkg.sv
sv/dsgl_divlane.sv
sv/direct_sum_gravity_leapfrog.sv
bench/tb_direct_sum_gravity_leapfrog.sv
